>>> design/u16e_pkg.sv
// shared types, constants and helper functions for the utf-16 to utf-8 encoder
// no dependencies
`default_nettype none

package u16e_pkg;

    // default depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int UNIT_W = 16;
    localparam int BYTE_W = 8;

    // surrogate tags held in the top six bits of a unit
    localparam logic [5:0] HIGH_SUR_TAG = 6'b110110;  // 0xd800..0xdbff
    localparam logic [5:0] LOW_SUR_TAG  = 6'b110111;  // 0xdc00..0xdfff

    localparam logic [20:0] SUPP_BASE = 21'h10000;

    localparam logic [BYTE_W-1:0] REPL_B0   = 8'hEF;
    localparam logic [BYTE_W-1:0] REPL_B1   = 8'hBF;
    localparam logic [BYTE_W-1:0] REPL_B2   = 8'hBD;
    localparam logic [BYTE_W-1:0] LEAD_4    = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_3    = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_2    = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_MARK = 8'h80;

    localparam logic [2:0] REPL_LEN = 3'd3;

    // one classified unit: optional replacement prefix, then up to four bytes
    typedef struct packed {
        logic                   repl;    // emit ef bf bd first
        logic                   eos;     // main byte is the terminator
        logic [2:0]             main_n;  // number of main bytes, 0..4
        logic [3:0][BYTE_W-1:0] bytes;   // main bytes, index 0 first
    } t_job;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [BYTE_W-1:0] repl_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            2'd0:    b = REPL_B0;
            2'd1:    b = REPL_B1;
            default: b = REPL_B2;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> design/u16e_if.sv
// stream interfaces for code units in and utf-8 bytes out
// depends on u16e_pkg
`default_nettype none

interface u16e_unit_if;
    logic                         valid;
    logic                         ready;
    logic [u16e_pkg::UNIT_W-1:0]  code_unit;

    modport source (output valid, output code_unit, input ready);
    modport sink   (input valid, input code_unit, output ready);
endinterface

interface u16e_byte_if;
    logic                         valid;
    logic                         ready;
    logic [u16e_pkg::BYTE_W-1:0]  out_byte;
    logic                         last_of_run;
    logic                         end_of_string;

    modport source (output valid, output out_byte, output last_of_run,
                    output end_of_string, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input end_of_string, output ready);
endinterface

`default_nettype wire

>>> design/u16e_front.sv
// front end: accepts code units, tracks the pending high surrogate, builds jobs
// depends on u16e_pkg and u16e_if
`default_nettype none

module u16e_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    u16e_unit_if.sink        i_unit,
    input  u16e_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output u16e_pkg::t_job   o_job
);

    logic        r_pend;
    logic [9:0]  r_pend_bits;
    logic        n_pend;
    logic [9:0]  n_pend_bits;

    logic [15:0] u;
    logic        is_high;
    logic        is_low;
    logic        pair;
    logic        accept;
    logic [20:0] cp;
    u16e_pkg::t_job job;

    assign u       = i_unit.code_unit;
    assign is_high = (u[15:10] == u16e_pkg::HIGH_SUR_TAG);
    assign is_low  = (u[15:10] == u16e_pkg::LOW_SUR_TAG);
    assign pair    = r_pend && is_low;
    assign cp      = u16e_pkg::SUPP_BASE + {1'b0, r_pend_bits, u[9:0]};

    assign i_unit.ready = !i_q_stat.full;
    assign accept       = i_unit.valid && !i_q_stat.full;

    always_comb begin
        job        = '0;
        job.repl   = r_pend && !is_low;
        n_pend      = 1'b0;
        n_pend_bits = u[9:0];
        if (pair) begin
            job.main_n   = 3'd4;
            job.bytes[0] = u16e_pkg::LEAD_4 | {5'd0, cp[20:18]};
            job.bytes[1] = u16e_pkg::CONT_MARK | {2'd0, cp[17:12]};
            job.bytes[2] = u16e_pkg::CONT_MARK | {2'd0, cp[11:6]};
            job.bytes[3] = u16e_pkg::CONT_MARK | {2'd0, cp[5:0]};
        end else if (u == '0) begin
            job.main_n = 3'd1;
            job.eos    = 1'b1;
        end else if (u[15:7] == '0) begin
            job.main_n   = 3'd1;
            job.bytes[0] = u[7:0];
        end else if (u[15:11] == '0) begin
            job.main_n   = 3'd2;
            job.bytes[0] = u16e_pkg::LEAD_2 | {3'd0, u[10:6]};
            job.bytes[1] = u16e_pkg::CONT_MARK | {2'd0, u[5:0]};
        end else if (is_high) begin
            n_pend = 1'b1;
        end else if (is_low) begin
            // stray low surrogate
            job.main_n   = u16e_pkg::REPL_LEN;
            job.bytes[0] = u16e_pkg::REPL_B0;
            job.bytes[1] = u16e_pkg::REPL_B1;
            job.bytes[2] = u16e_pkg::REPL_B2;
        end else begin
            job.main_n   = 3'd3;
            job.bytes[0] = u16e_pkg::LEAD_3 | {4'd0, u[15:12]};
            job.bytes[1] = u16e_pkg::CONT_MARK | {2'd0, u[11:6]};
            job.bytes[2] = u16e_pkg::CONT_MARK | {2'd0, u[5:0]};
        end
    end

    assign o_job  = job;
    assign o_push = accept && (job.repl || (job.main_n != 3'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_pend_bits <= '0;
        end else if (accept) begin
            r_pend      <= n_pend;
            r_pend_bits <= n_pend ? n_pend_bits : '0;
        end
    end

endmodule

`default_nettype wire

>>> design/u16e_queue.sv
// small job queue between front and back, first word visible at the head
// depends on u16e_pkg
`default_nettype none

module u16e_queue #(
    parameter int DEPTH = u16e_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  u16e_pkg::t_job     i_job,
    input  wire                i_pop,
    output u16e_pkg::t_job     o_head,
    output u16e_pkg::t_q_stat  o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u16e_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/u16e_back.sv
// back end: walks the head job one byte per cycle into the output register while o_byte is ready
// depends on u16e_pkg and u16e_if
`default_nettype none

module u16e_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  u16e_pkg::t_job    i_head,
    input  u16e_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    u16e_byte_if.source       o_byte
);

    logic [2:0]  r_step;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_last;
    logic        r_eos;

    logic        adv;
    logic        load;
    logic [2:0]  pre_n;
    logic [2:0]  total;
    logic [2:0]  main_idx;
    logic        in_repl;
    logic        is_last;
    logic [7:0]  n_byte;

    assign pre_n    = i_head.repl ? u16e_pkg::REPL_LEN : 3'd0;
    assign total    = pre_n + i_head.main_n;
    assign main_idx = r_step - pre_n;
    assign in_repl  = i_head.repl && (r_step < u16e_pkg::REPL_LEN);
    assign is_last  = (r_step == total - 3'd1);
    assign n_byte   = in_repl ? u16e_pkg::repl_byte(r_step[1:0])
                              : i_head.bytes[main_idx[1:0]];

    assign adv   = !r_valid || o_byte.ready;
    assign load  = adv && !i_q_stat.empty;
    assign o_pop = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            if (adv) begin
                r_valid <= !i_q_stat.empty;
            end
            if (load) begin
                r_step <= is_last ? 3'd0 : r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= n_byte;
            r_last <= is_last;
            r_eos  <= is_last && i_head.eos;
        end
    end

    assign o_byte.valid         = r_valid;
    assign o_byte.out_byte      = r_byte;
    assign o_byte.last_of_run   = r_last;
    assign o_byte.end_of_string = r_eos;

endmodule

`default_nettype wire

>>> design/utf16_to_utf8_encoder.sv
// top level of the utf-16 to utf-8 encoder: front, job queue and back
// depends on u16e_pkg, u16e_if, u16e_front, u16e_queue and u16e_back
//
//  port      dir  request         fields
//  i_unit    in   one code unit   code_unit[15:0]
//  o_byte    out  one utf-8 byte  out_byte[7:0], last_of_run, end_of_string
//
//  a code unit is accepted in any cycle the job queue has room, so units enter
//  back to back; its bytes leave one per cycle while o_byte is ready, up to six
//  per unit (one byte per cycle on o_byte sets the rate); a held high
//  surrogate yields no output byte; the first byte passes through the queue
//  and then the output register; reset is synchronous and clears the pending
//  surrogate, queue and output register; o_byte stalls back up through the queue
`default_nettype none

module utf16_to_utf8_encoder #(
    parameter int QUEUE_DEPTH = u16e_pkg::QUEUE_DEPTH_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    u16e_unit_if.sink    i_unit,
    u16e_byte_if.source  o_byte
);

    // classified job from front to queue
    u16e_pkg::t_job    push_job;
    logic              push;
    // head of queue to back
    u16e_pkg::t_job    head_job;
    logic              pop;
    u16e_pkg::t_q_stat q_stat;

    // front keeps the pending high surrogate and turns units into jobs
    u16e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_unit   (i_unit),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    // decouples unit acceptance from byte output
    u16e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (q_stat)
    );

    // back emits replacement prefix then main bytes, one per cycle while o_byte is ready
    u16e_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_byte   (o_byte)
    );

    // the terminator byte always closes its run
    a_eos_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_byte.valid && o_byte.end_of_string |-> o_byte.last_of_run)
        else $error("terminator byte not marked last of run");

    // the terminator byte is zero
    a_eos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_byte.valid && o_byte.end_of_string |-> (o_byte.out_byte == 8'h00))
        else $error("terminator byte not zero");

    // every byte before the last of a run belongs to a multi-byte sequence
    a_mid_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_byte.valid && !o_byte.last_of_run |-> o_byte.out_byte[7])
        else $error("ascii byte inside a multi-byte run");

endmodule

`default_nettype wire
